// ===== sv/brfa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brfa_pkg
// Shared types and constants for the bitwise register file ALU.
// ----------------------------------------------------------------------------
package brfa_pkg;

   localparam int NUM_REGS   = 26;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = 5;

   typedef enum logic [1:0] {
      KIND_LOGIC = 2'd0,
      KIND_NOT   = 2'd1,
      KIND_LOAD  = 2'd2,
      KIND_STORE = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      LOP_OR    = 4'd0,
      LOP_AND   = 4'd1,
      LOP_IMPL  = 4'd2,
      LOP_RIMPL = 4'd3,
      LOP_EQUIV = 4'd4,
      LOP_XOR   = 4'd5,
      LOP_COIMP = 4'd6,
      LOP_NAND  = 4'd7,
      LOP_NOR   = 4'd8
   } lop_type;

   typedef struct packed {
      kind_type                kind;
      logic [IDX_W-1:0]        dest_index;
      logic [IDX_W-1:0]        src_a_index;
      logic [IDX_W-1:0]        src_b_index;
      lop_type                 logic_op;
      logic [DATA_WIDTH-1:0]   load_value;
   } req_word_type;

   typedef struct packed {
      logic                    status;
      logic                    out_valid;
      logic [DATA_WIDTH-1:0]   out_value;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic read;
      logic exec;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_full;
   } stat_type;

   function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
      logic [IDX_W:0] lim;
      lim = (IDX_W+1)'(NUM_REGS);
      return {1'b0, idx} < lim;
   endfunction

endpackage : brfa_pkg
`default_nettype wire

// ===== sv/brfa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brfa_ctrl
// Sequencer: accept, register read, execute/writeback.
// ----------------------------------------------------------------------------
module brfa_ctrl
   import brfa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   always_comb begin
      cmd.capture = req_valid && ready_ff;
      cmd.read    = (state_ff == ST_READ);
      cmd.exec    = (state_ff == ST_EXEC) && !stat.out_full;
   end

   assign req_ready = ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && ready_ff) begin
                  state_ff <= ST_READ;
                  ready_ff <= 1'b0;
               end
            end
            ST_READ: begin
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               // hold until the output register can take the result
               if (!stat.out_full) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule : brfa_ctrl
`default_nettype wire

// ===== sv/brfa_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brfa_datapath
// Register bank, logic unit and output register.
// ----------------------------------------------------------------------------
module brfa_datapath
   import brfa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_word_type req_word,
   input  wire cmd_type      cmd,
   output stat_type          stat,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word
);

   req_word_type            in_ff;
   logic [DATA_WIDTH-1:0]   mem_ff [NUM_REGS];
   logic [NUM_REGS-1:0]     vld_ff;
   logic [DATA_WIDTH-1:0]   rd_a_ff, rd_b_ff;
   logic [DATA_WIDTH-1:0]   rd_a_in, rd_b_in;
   logic                    rsp_valid_ff;
   rsp_word_type            rsp_word_ff, rsp_word_in;
   logic [IDX_W-1:0]        addr_a;
   logic                    ok;
   logic                    wr_en;
   logic [DATA_WIDTH-1:0]   result;

   // store reads its register through port a
   assign addr_a = (in_ff.kind == KIND_STORE) ? in_ff.dest_index : in_ff.src_a_index;

   always_comb begin
      rd_a_in = '0;
      rd_b_in = '0;
      if (idx_ok(addr_a) && vld_ff[addr_a])
         rd_a_in = mem_ff[addr_a];
      if (idx_ok(in_ff.src_b_index) && vld_ff[in_ff.src_b_index])
         rd_b_in = mem_ff[in_ff.src_b_index];
   end

   always_comb begin
      case (in_ff.kind)
         KIND_LOGIC: ok = idx_ok(in_ff.dest_index) && idx_ok(in_ff.src_a_index)
                          && idx_ok(in_ff.src_b_index);
         KIND_NOT:   ok = idx_ok(in_ff.dest_index) && idx_ok(in_ff.src_a_index);
         default:    ok = idx_ok(in_ff.dest_index);
      endcase
   end

   always_comb begin
      case (in_ff.kind)
         KIND_LOGIC: begin
            case (in_ff.logic_op)
               LOP_OR:    result = rd_a_ff | rd_b_ff;
               LOP_AND:   result = rd_a_ff & rd_b_ff;
               LOP_IMPL:  result = ~rd_a_ff | rd_b_ff;
               LOP_RIMPL: result = rd_a_ff | ~rd_b_ff;
               LOP_EQUIV: result = ~(rd_a_ff ^ rd_b_ff);
               LOP_XOR:   result = rd_a_ff ^ rd_b_ff;
               LOP_COIMP: result = rd_a_ff & ~rd_b_ff;
               LOP_NAND:  result = ~(rd_a_ff & rd_b_ff);
               LOP_NOR:   result = ~(rd_a_ff | rd_b_ff);
               default:   result = '0;
            endcase
         end
         KIND_NOT:  result = ~rd_a_ff;
         KIND_LOAD: result = in_ff.load_value;
         default:   result = '0;
      endcase
   end

   assign wr_en = cmd.exec && ok && (in_ff.kind != KIND_STORE);

   always_comb begin
      rsp_word_in.status    = !ok;
      rsp_word_in.out_valid = ok && (in_ff.kind == KIND_STORE);
      rsp_word_in.out_value = rsp_word_in.out_valid ? rd_a_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture)
         in_ff <= req_word;
      if (cmd.read) begin
         rd_a_ff <= rd_a_in;
         rd_b_ff <= rd_b_in;
      end
      if (wr_en)
         mem_ff[in_ff.dest_index] <= result;
      if (cmd.exec)
         rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en)
            vld_ff[in_ff.dest_index] <= 1'b1;
         if (cmd.exec)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   assign stat.out_full = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word      = rsp_word_ff;

endmodule : brfa_datapath
`default_nettype wire

// ===== sv/bitwise_register_file_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bitwise_register_file_alu
// 26 x 32-bit register file with a nine-function boolean logic unit.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction | moves
//  --------+--------------------------------+-----------+---------------------
//  request | req_valid, req_ready, req_word | in        | one instruction word
//  response| rsp_valid, rsp_ready, rsp_word | out       | one status word
//
//  Each instruction goes through accept, register read (two read ports,
//  registered), then execute with writeback into the bank and the output
//  register; the next word is accepted the cycle after execute.
//  Reset clears the bank through per-register valid bits.
//  A stalled response holds execute until the output register drains; a
//  finished response may wait while the next word is accepted and read.
// ----------------------------------------------------------------------------
module bitwise_register_file_alu
   import brfa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   brfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // bank, logic unit, output register
   brfa_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule : bitwise_register_file_alu
`default_nettype wire
